>>> rtl/htev_pkg.sv
package htev_pkg;

   // Wide serial multiplier: a 64 by 64 bit product built one 16 bit digit per cycle.
   localparam int MUL_W   = 64;
   localparam int DIGIT_W = 16;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 40;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CONSTITUENT_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAN_LEVEL        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EPOCH_SECONDS     = 2'd2;

   // Opcodes carried in tuser.
   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_EVALUATE = 1'b1;

   // Default values for the top level parameters.
   localparam int DEF_MAX_CONSTITUENTS = 32;
   localparam int DEF_CORDIC_STEPS     = 24;

   // Start vector of the CORDIC, Q4.30, and one radian per hour per turn per second, Q32.
   localparam logic signed [33:0] CORDIC_GAIN       = 34'sd652032874;
   localparam logic [MUL_W-1:0]   RAD_PER_HOUR_Q32  = 64'd97149871472559;

   // atan(2^-i) in turns, Q0.32.
   localparam logic [31:0] TURN_ATAN [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic [31:0] phase;
      logic [47:0] rate;
      logic [23:0] amp;
   } entry_type;

   // Round to nearest with ties upward at bit position sh, then saturate to 32 bits.
   function automatic logic [31:0] round_sat(input logic signed [63:0] v, input int sh);
      logic signed [63:0] r;
      r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
      if (r > 64'sd2147483647) begin
         round_sat = 32'h7FFFFFFF;
      end else if (r < -64'sd2147483648) begin
         round_sat = 32'h80000000;
      end else begin
         round_sat = r[31:0];
      end
   endfunction

endpackage

>>> rtl/harmonic_tide_evaluator.sv
// Harmonic tide evaluator.
// The req channel carries items of two kinds, chosen by req_tuser: a load item writes one
// constituent (amplitude, rate, phase) into the table slot entry_index, and an evaluate
// item gives a time in seconds. Each evaluate item yields one rsp item with height, slope
// and curvature; a load item yields none. The csr channel writes constituent_count,
// mean_level and epoch_seconds; it is always ready. The user is to write it only while
// the block is idle; the block itself does not enforce this. A load item is written
// into the table as it is accepted. Per active constituent, an evaluate item runs the
// CORDIC iterations (one per cycle) and four serial passes through the 16 bit digit-serial
// multiplier; the pass that forms the rate in radians per hour runs beside the CORDIC.
// The block works on one item at a time; req_tready is high only when no evaluation runs.
// A finished result waits in the rsp output register; a new item is taken while it waits,
// and a following evaluation holds its result until the receiver takes the previous one.
// Synchronous reset clears the configuration registers, the controller and rsp_tvalid.
// Table contents are not cleared; a slot is to be loaded before it is included in a sum.
module harmonic_tide_evaluator
   import htev_pkg::*;
#(
   parameter int MAX_CONSTITUENTS = DEF_MAX_CONSTITUENTS,
   parameter int CORDIC_STEPS     = DEF_CORDIC_STEPS
) (
   input  logic                  clock,
   input  logic                  reset,
   // Fields from bit 0: entry_index[4:0], amplitude[28:5], rate_turns[76:29],
   // phase_turns[108:77], time_seconds[148:109], zero fill.
   input  logic [151:0]          req_tdata,
   // Fields from bit 0: opcode.
   input  logic                  req_tuser,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // Fields from bit 0: height[31:0], slope[63:32], curvature[95:64].
   output logic [95:0]           rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int IDX_W = (MAX_CONSTITUENTS > 1) ? $clog2(MAX_CONSTITUENTS) : 1;
   localparam logic [6:0] MAX7 = 7'(MAX_CONSTITUENTS);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_READ     = 4'd1;
   localparam logic [3:0] S_ANG_GO   = 4'd2;
   localparam logic [3:0] S_ANG_WAIT = 4'd3;
   localparam logic [3:0] S_CW_GO    = 4'd4;
   localparam logic [3:0] S_CW_WAIT  = 4'd5;
   localparam logic [3:0] S_PROD     = 4'd6;
   localparam logic [3:0] S_SL_GO    = 4'd7;
   localparam logic [3:0] S_SL_WAIT  = 4'd8;
   localparam logic [3:0] S_C1_GO    = 4'd9;
   localparam logic [3:0] S_C1_WAIT  = 4'd10;
   localparam logic [3:0] S_C2_GO    = 4'd11;
   localparam logic [3:0] S_C2_WAIT  = 4'd12;
   localparam logic [3:0] S_FINISH   = 4'd13;

   // Request fields.
   logic [4:0]          entry_index;
   logic [23:0]         amplitude;
   logic [47:0]         rate_turns;
   logic [31:0]         phase_turns;
   logic signed [39:0]  time_seconds;

   assign entry_index  = req_tdata[4:0];
   assign amplitude    = req_tdata[28:5];
   assign rate_turns   = req_tdata[76:29];
   assign phase_turns  = req_tdata[108:77];
   assign time_seconds = $signed(req_tdata[148:109]);

   // Configuration registers.
   logic [5:0]         count_ff;
   logic signed [23:0] mean_ff;
   logic signed [39:0] epoch_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         mean_ff  <= '0;
         epoch_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CONSTITUENT_COUNT: count_ff <= csr_data[5:0];
            CSR_MEAN_LEVEL:        mean_ff  <= $signed(csr_data[23:0]);
            CSR_EPOCH_SECONDS:     epoch_ff <= $signed(csr_data[39:0]);
            default: ;
         endcase
      end
   end

   // Controller state.
   logic [3:0]  state_ff, state_in;
   logic [6:0]  k_ff, k_in, n_ff, n_in;
   logic        req_acc, rsp_free;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_free   = !rsp_tvalid || rsp_tready;

   // Constituent table. A load whose slot lies beyond the table is dropped.
   logic [6:0] idx7;
   logic       wr_en;
   entry_type  wr_entry, entry;

   assign idx7     = 7'(entry_index);
   assign wr_en    = req_acc && (req_tuser == OP_LOAD) && (idx7 < MAX7);
   assign wr_entry = '{phase: phase_turns, rate: rate_turns, amp: amplitude};

   htev_table #(
      .DEPTH (MAX_CONSTITUENTS),
      .IDX_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx7[IDX_W-1:0]),
      .wr_data (wr_entry),
      .rd_addr (k_ff[IDX_W-1:0]),
      .rd_data (entry)
   );

   // Shared digit-serial multiplier.
   logic                mul_start, mul_busy;
   logic [MUL_W-1:0]    mul_a, mul_b;
   logic [2*MUL_W-1:0]  mul_p;

   htev_digit_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .busy    (mul_busy),
      .product (mul_p)
   );

   // CORDIC unit.
   logic               cor_busy;
   logic signed [33:0] cos_v, sin_v;
   logic [31:0]        ang_ff, ang_in;

   htev_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (state_ff == S_CW_GO),
      .angle   (ang_ff),
      .busy    (cor_busy),
      .cos_out (cos_v),
      .sin_out (sin_v)
   );

   // Datapath registers.
   logic signed [40:0] dt_ff, dt_in;
   logic signed [63:0] h_ff, h_in, sl_ff, sl_in, cv_ff, cv_in;
   logic signed [63:0] v_ff, v_in, u_ff, u_in;
   logic [MUL_W-1:0]   w_ff, w_in, t1_ff, t1_in, mag_u, mag_v;
   logic signed [57:0] v_prod, u_prod;
   logic [47:0]        ang48;
   logic [95:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_valid_ff, rsp_valid_in;

   assign v_prod = $signed(entry.amp) * cos_v;
   assign u_prod = $signed(entry.amp) * sin_v;
   assign mag_u  = u_ff[63] ? 64'(-u_ff) : 64'(u_ff);
   assign mag_v  = v_ff[63] ? 64'(-v_ff) : 64'(v_ff);
   assign ang48  = mul_p[47:0] - {entry.phase, 16'h0000};

   // Operands for each multiplier pass: the angle product, the rate in radians per hour,
   // the slope term and the two curvature passes.
   always_comb begin
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         S_ANG_GO: begin
            mul_start = 1'b1;
            mul_a     = 64'(entry.rate);
            mul_b     = 64'({{7{dt_ff[40]}}, dt_ff});
         end
         S_CW_GO: begin
            mul_start = 1'b1;
            mul_a     = 64'(entry.rate);
            mul_b     = RAD_PER_HOUR_Q32;
         end
         S_SL_GO: begin
            mul_start = 1'b1;
            mul_a     = mag_u;
            mul_b     = w_ff;
         end
         S_C1_GO: begin
            mul_start = 1'b1;
            mul_a     = mag_v;
            mul_b     = w_ff;
         end
         S_C2_GO: begin
            mul_start = 1'b1;
            mul_a     = t1_ff;
            mul_b     = w_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      dt_in        = dt_ff;
      h_in         = h_ff;
      sl_in        = sl_ff;
      cv_in        = cv_ff;
      v_in         = v_ff;
      u_in         = u_ff;
      w_in         = w_ff;
      t1_in        = t1_ff;
      ang_in       = ang_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_acc && (req_tuser == OP_EVALUATE)) begin
               dt_in = 41'(time_seconds) - 41'(epoch_ff);
               h_in  = {{10{mean_ff[23]}}, mean_ff, 30'd0};
               sl_in = '0;
               cv_in = '0;
               k_in  = '0;
               n_in  = ({1'b0, count_ff} > MAX7) ? MAX7 : 7'(count_ff);
               if (count_ff == 6'd0) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ:   state_in = S_ANG_GO;
         S_ANG_GO: state_in = S_ANG_WAIT;
         S_ANG_WAIT: begin
            if (!mul_busy) begin
               ang_in   = ang48[47:16];
               state_in = S_CW_GO;
            end
         end
         S_CW_GO: state_in = S_CW_WAIT;
         S_CW_WAIT: begin
            if (!mul_busy && !cor_busy) begin
               w_in     = mul_p[48 +: MUL_W];
               state_in = S_PROD;
            end
         end
         S_PROD: begin
            v_in     = 64'(v_prod);
            u_in     = 64'(u_prod);
            state_in = S_SL_GO;
         end
         S_SL_GO: begin
            h_in     = h_ff + v_ff;
            state_in = S_SL_WAIT;
         end
         S_SL_WAIT: begin
            if (!mul_busy) begin
               // Each term is negated against the sign of its product.
               sl_in    = u_ff[63] ? sl_ff + $signed(mul_p[46 +: MUL_W])
                                   : sl_ff - $signed(mul_p[46 +: MUL_W]);
               state_in = S_C1_GO;
            end
         end
         S_C1_GO: state_in = S_C1_WAIT;
         S_C1_WAIT: begin
            if (!mul_busy) begin
               t1_in    = mul_p[40 +: MUL_W];
               state_in = S_C2_GO;
            end
         end
         S_C2_GO: state_in = S_C2_WAIT;
         S_C2_WAIT: begin
            if (!mul_busy) begin
               cv_in = v_ff[63] ? cv_ff + $signed(mul_p[50 +: MUL_W])
                                : cv_ff - $signed(mul_p[50 +: MUL_W]);
               k_in  = k_ff + 1'b1;
               if (k_ff + 1'b1 == n_ff) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_data_in  = {round_sat(cv_ff, 4), round_sat(sl_ff, 16),
                               round_sat(h_ff, 30)};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         k_ff         <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff       <= dt_in;
      h_ff        <= h_in;
      sl_ff       <= sl_in;
      cv_ff       <= cv_in;
      v_ff        <= v_in;
      u_ff        <= u_in;
      w_ff        <= w_in;
      t1_ff       <= t1_in;
      ang_ff      <= ang_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;

   // A load item leaves the controller idle.
   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_tuser == OP_LOAD)) |=> (state_ff == S_IDLE))
      else $error("load item started an evaluation");

   // An evaluate item always starts work.
   a_eval_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_tuser == OP_EVALUATE)) |=> (state_ff != S_IDLE))
      else $error("evaluate item was not started");

   // The multiplier is never restarted during a pass.
   a_mul_no_overlap: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_busy)
      else $error("multiplier restarted while busy");

   // The constituent counter stays inside the active range while a sum is formed.
   a_k_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> (k_ff < n_ff))
      else $error("constituent counter out of range");

endmodule

>>> rtl/htev_digit_mul.sv
module htev_digit_mul
   import htev_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MUL_W-1:0]     a,
   input  logic [MUL_W-1:0]     b,
   output logic                 busy,
   output logic [2*MUL_W-1:0]   product
);

   localparam int DIGITS = MUL_W / DIGIT_W;
   localparam int CNT_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam logic [CNT_W-1:0] LAST = CNT_W'(DIGITS - 1);

   logic [MUL_W-1:0] a_ff, b_ff, acc_ff, low_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic [MUL_W+DIGIT_W-1:0] sum;

   // While busy, each cycle adds one digit's partial product and retires the low digit.
   assign sum = {{DIGIT_W{1'b0}}, acc_ff} + a_ff * b_ff[DIGIT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= '0;
         low_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= sum[MUL_W+DIGIT_W-1:DIGIT_W];
         low_ff <= {sum[DIGIT_W-1:0], low_ff[MUL_W-1:DIGIT_W]};
         b_ff   <= b_ff >> DIGIT_W;
      end
   end

   assign busy    = busy_ff;
   assign product = {acc_ff, low_ff};

endmodule

>>> rtl/htev_cordic.sv
module htev_cordic
   import htev_pkg::*;
#(
   parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [31:0]        angle,
   output logic               busy,
   output logic signed [33:0] cos_out,
   output logic signed [33:0] sin_out
);

   localparam int STEP_W = $clog2(CORDIC_STEPS + 1);
   localparam logic [STEP_W-1:0] LAST = STEP_W'(CORDIC_STEPS - 1);

   logic signed [33:0] x_ff, y_ff, z_ff, xs, ys, at;
   logic [STEP_W-1:0]  step_ff;
   logic [4:0]         sidx;
   logic               busy_ff, flip_ff, flip;

   // Second and third quadrant angles are turned by half a turn.
   assign flip = angle[31] ^ angle[30];
   assign sidx = 5'(step_ff);
   assign xs   = x_ff >>> sidx;
   assign ys   = y_ff >>> sidx;
   assign at   = $signed({2'b00, TURN_ATAN[sidx]});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         if (step_ff == LAST) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= CORDIC_GAIN;
         y_ff    <= '0;
         z_ff    <= 34'($signed(flip ? {~angle[31], angle[30:0]} : angle));
         flip_ff <= flip;
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + at;
         end
      end
   end

   assign busy    = busy_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;

endmodule

>>> rtl/htev_table.sv
module htev_table
   import htev_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_CONSTITUENTS,
   parameter int IDX_W = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the harmonic tide evaluator.
// Load items fill the constituent table and evaluate items each produce one item
// of height, slope and curvature. A bit-exact predictor in this file computes
// every expected item. The checker compares each response item, field by field,
// with the oldest entry of the queue of expected tide values.
module testbench
   import htev_pkg::*;
();

   localparam int  TABLE_DEPTH  = DEF_MAX_CONSTITUENTS;
   localparam int  STEPS        = DEF_CORDIC_STEPS;
   localparam int  CYCLE_LIMIT  = 3000000;
   localparam int  DRAIN_CYCLES = 100;

   typedef struct packed {
      logic [31:0] curvature;
      logic [31:0] slope;
      logic [31:0] height;
   } tide_vals_type;

   logic                  clock;
   logic                  reset;
   logic [151:0]          req_tdata;
   logic                  req_tuser;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [95:0]           rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   harmonic_tide_evaluator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Shadow copy of the block's configuration and constituent table.
   logic [5:0]         count_reg;
   logic signed [23:0] mean_reg;
   logic signed [39:0] epoch_reg;
   logic [23:0]        amp_tab   [TABLE_DEPTH];
   logic [47:0]        rate_tab  [TABLE_DEPTH];
   logic [31:0]        phase_tab [TABLE_DEPTH];

   tide_vals_type expected_tides [$];
   int errors = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout with %0d items outstanding", $time, expected_tides.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // The receiver stalls at random; ready changes only at the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Every accepted response item is matched against the oldest expected one.
   always @(posedge clock) begin
      tide_vals_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_tides.size() == 0) begin
            $display("%0t unexpected item %h", $time, got);
            errors++;
         end else begin
            want = expected_tides.pop_front();
            if (got.height !== want.height) begin
               $display("%0t height expected %h actual %h", $time, want.height, got.height);
               errors++;
            end
            if (got.slope !== want.slope) begin
               $display("%0t slope expected %h actual %h", $time, want.slope, got.slope);
               errors++;
            end
            if (got.curvature !== want.curvature) begin
               $display("%0t curvature expected %h actual %h", $time, want.curvature,
                        got.curvature);
               errors++;
            end
         end
      end
   end

   // Full-width product shifted right, truncated to 64 bits.
   function automatic logic [63:0] product_shr(input logic [63:0] a, input logic [63:0] b,
                                                input int sh);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return 64'(p >> sh);
   endfunction

   // Round to nearest with ties upward, then clamp to 32 bits.
   function automatic logic [31:0] round_clamp(input logic signed [63:0] v, input int sh);
      logic signed [63:0] r;
      r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
      if (r > 64'sd2147483647) return 32'h7FFFFFFF;
      if (r < -64'sd2147483648) return 32'h80000000;
      return r[31:0];
   endfunction

   // Harmonic sum at time t using the shadow table and configuration.
   function automatic tide_vals_type predict_tide(input logic signed [39:0] t);
      tide_vals_type      res;
      int                 n;
      logic signed [63:0] dt, h, sl, cv, x, y, z, xs, ys, c, s, amp, v, u;
      logic [63:0]        rate, w, ang, ph, mag, term;
      logic [31:0]        a;
      logic [1:0]         q;
      bit                 flip;
      n = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : count_reg;
      dt = t;
      dt = dt - epoch_reg;
      h = mean_reg;
      h = h <<< 30;
      sl = 0;
      cv = 0;
      for (int k = 0; k < n; k++) begin
         amp = $signed(amp_tab[k]);
         rate = rate_tab[k];
         ph = phase_tab[k];
         w = product_shr(rate, RAD_PER_HOUR_Q32, 48);
         ang = rate * dt - (ph << 16);
         a = ang[47:16];
         q = a[31:30];
         // Second and third quadrant: rotate by half a turn and negate afterwards.
         flip = (q == 2'd1) || (q == 2'd2);
         z = {32'd0, a};
         if (flip) z = z - 64'sd2147483648;
         else if (q == 2'd3) z = z - 64'sd4294967296;
         x = CORDIC_GAIN;
         y = 0;
         for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x = x - ys;
               y = y + xs;
               z = z - $signed({32'd0, TURN_ATAN[i]});
            end else begin
               x = x + ys;
               y = y - xs;
               z = z + $signed({32'd0, TURN_ATAN[i]});
            end
         end
         c = flip ? -x : x;
         s = flip ? -y : y;
         v = amp * c;
         u = amp * s;
         h = h + v;
         mag = (u < 0) ? -u : u;
         term = product_shr(mag, w, 46);
         if (u > 0) sl = sl - $signed(term);
         else sl = sl + $signed(term);
         mag = (v < 0) ? -v : v;
         term = product_shr(product_shr(mag, w, 40), w, 50);
         if (v > 0) cv = cv - $signed(term);
         else cv = cv + $signed(term);
      end
      res.height = round_clamp(h, 30);
      res.slope = round_clamp(sl, 16);
      res.curvature = round_clamp(cv, 4);
      return res;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Sends one item and, once accepted, updates the shadow state or queues a result.
   task automatic send_item(input logic op, input logic [4:0] idx, input logic [23:0] amp,
                            input logic [47:0] rate, input logic [31:0] phase,
                            input logic [39:0] t);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'd0, t, phase, rate, amp, idx};
      do @(posedge clock); while (!req_tready);
      if (op == OP_LOAD) begin
         amp_tab[idx]   = amp;
         rate_tab[idx]  = rate;
         phase_tab[idx] = phase;
      end else begin
         expected_tides.push_back(predict_tide(t));
      end
   endtask

   task automatic send_load(input logic [4:0] idx, input logic [23:0] amp,
                            input logic [47:0] rate, input logic [31:0] phase);
      send_item(OP_LOAD, idx, amp, rate, phase, 40'(rand64()));
   endtask

   task automatic send_eval(input logic [39:0] t);
      send_item(OP_EVALUATE, 5'($urandom()), 24'($urandom()), 48'(rand64()), $urandom(), t);
   endtask

   // Drops valid and waits until every result is in and the block has settled.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_tides.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CONSTITUENT_COUNT: count_reg = val[5:0];
         CSR_MEAN_LEVEL:        mean_reg  = val[23:0];
         CSR_EPOCH_SECONDS:     epoch_reg = val[39:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [5:0] n, input logic [23:0] mean,
                            input logic [39:0] epoch);
      wait_idle();
      csr_write(CSR_CONSTITUENT_COUNT, CSR_DATA_W'(n));
      csr_write(CSR_MEAN_LEVEL, CSR_DATA_W'(mean));
      csr_write(CSR_EPOCH_SECONDS, epoch);
   endtask

   // Right after reset no constituent is active, so only the mean level counts.
   task automatic test_empty_sum();
      send_eval(40'h0);
      configure(6'd0, 24'h7FFFFF, 40'h0);
      send_eval(40'h7FFFFFFFFF);
      configure(6'd0, 24'h800000, 40'h8000000000);
      send_eval(40'h7FFFFFFFFF);
   endtask

   // Fill every slot, with the field extremes placed in the first few.
   task automatic test_table_fill();
      send_load(5'd0, 24'h7FFFFF, 48'hFFFFFFFFFFFF, 32'hFFFFFFFF);
      send_load(5'd1, 24'h800000, 48'h0, 32'h0);
      send_load(5'd2, 24'h800000, 48'hFFFFFFFFFFFF, 32'h80000000);
      send_load(5'd3, 24'h010000, 48'h000001000000, 32'h40000000);
      for (int k = 4; k < TABLE_DEPTH; k++) begin
         send_load(5'(k), 24'($urandom()), 48'(rand64()), $urandom());
      end
   endtask

   // Count extremes, including a count beyond the table depth, and time extremes.
   task automatic test_extremes();
      configure(6'd1, 24'h0, 40'h0);
      send_eval(40'h0);
      send_eval(40'h7FFFFFFFFF);
      configure(6'd3, 24'h7FFFFF, 40'h7FFFFFFFFF);
      send_eval(40'h8000000000);
      send_eval(40'h7FFFFFFFFF);
      configure(6'd32, 24'h800000, 40'h8000000000);
      send_eval(40'h7FFFFFFFFF);
      send_eval(40'h8000000000);
      configure(6'd63, 24'h123456, 40'h0);
      send_eval(40'(rand64()));
   endtask

   // Mostly small sums for speed, with a few full-table settings.
   task automatic test_random(input int items, input int idle_pct, input int stall_pct);
      logic [5:0] n;
      wait_idle();
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int blk = 0; blk < 4; blk++) begin
         case ($urandom_range(7))
            0:       n = 6'd32;
            1:       n = 6'($urandom_range(33, 63));
            default: n = 6'($urandom_range(0, 5));
         endcase
         configure(n, 24'($urandom()), 40'(rand64()));
         for (int k = 0; k < items / 4; k++) begin
            if ($urandom_range(99) < 35) begin
               send_load(5'($urandom()), 24'($urandom()), 48'(rand64()), $urandom());
            end else begin
               send_eval(40'(rand64()));
            end
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = OP_LOAD;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      rsp_tready = 1'b0;
      count_reg  = '0;
      mean_reg   = '0;
      epoch_reg  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_sum();
      test_table_fill();
      test_extremes();
      test_random(100, 0, 0);
      test_random(100, 70, 0);
      test_random(100, 0, 70);
      test_random(100, 20, 20);

      wait_idle();
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/htev_pkg.sv
rtl/htev_digit_mul.sv
rtl/htev_cordic.sv
rtl/htev_table.sv
rtl/harmonic_tide_evaluator.sv
dv/testbench.sv
